### hdl/assert_macros.svh
// Assertion macros used by the clipper back end.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RHPC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define RHPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define RHPC_ASSERT(lbl, expr)
`define RHPC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### hdl/rhpc_pkg.sv
// Shared widths, codes and types of the rectangle half-plane clipper.
// No dependencies; the interface, RTL and bench files use this package.
package rhpc_pkg;

  localparam int COORD_W       = 32;
  localparam int DIR_FRAC_BITS = 14;
  localparam int DIR_W         = DIR_FRAC_BITS + 2;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int DIRN_W        = DIR_W + 1;
  localparam int PROD_W        = DIFF_W + DIRN_W;
  localparam int CROSS_W       = PROD_W + 1;
  localparam int CFG_DATA_W    = (COORD_W > DIR_W) ? COORD_W : DIR_W;
  localparam int CFG_IDX_W     = 3;

  // Divider retires DIV_RADIX quotient bits per cycle.
  localparam int DIV_RADIX = 8;
  localparam int DIV_STEPS = (COORD_W + 1 + DIV_RADIX - 1) / DIV_RADIX;
  localparam int QUO_W     = DIV_STEPS * DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Two emission slots per corner: the corner itself, then its edge crossing.
  localparam int NSLOT  = 8;
  localparam int SLOT_W = 3;

  localparam logic [1:0] CLS_FULL    = 2'd0;
  localparam logic [1:0] CLS_EMPTY   = 2'd1;
  localparam logic [1:0] CLS_PARTIAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic signed [DIRN_W-1:0]  dirn_t;
  typedef logic signed [CROSS_W-1:0] cross_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    dir_t   dx;
    dir_t   dy;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cls;
    logic [NSLOT-1:0] mask;
    coord_t           x1;
    coord_t           y1;
    coord_t           x2;
    coord_t           y2;
    dirn_t            dxn;
    dirn_t            dyn;
    cross_t [3:0]     cr;
  } entry_t;

endpackage

### hdl/rhpc_chan_if.sv
// Valid/ready channel interfaces for the clipper's rectangle and vertex streams.
// Depends on rhpc_pkg for field widths.
interface rhpc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rhpc_pkg::COORD_W-1:0] rect_left;
  logic signed [rhpc_pkg::COORD_W-1:0] rect_bottom;
  logic signed [rhpc_pkg::COORD_W-1:0] rect_right;
  logic signed [rhpc_pkg::COORD_W-1:0] rect_top;
  logic                                keep_right;
  modport source (output valid, rect_left, rect_bottom, rect_right, rect_top,
                  keep_right, input ready);
  modport sink (input valid, rect_left, rect_bottom, rect_right, rect_top,
                keep_right, output ready);
endinterface

interface rhpc_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          region_class;
  logic signed [rhpc_pkg::COORD_W-1:0] vertex_x;
  logic signed [rhpc_pkg::COORD_W-1:0] vertex_y;
  logic                                last_vertex;
  modport source (output valid, region_class, vertex_x, vertex_y, last_vertex,
                  input ready);
  modport sink (input valid, region_class, vertex_x, vertex_y, last_vertex,
                output ready);
endinterface

### hdl/rect_half_plane_clipper_core.sv
// Rectangle half-plane clipper, top level. A request passes 3 front stages, the
// queue, the back end and the output register on its way to the first result.
// Full or empty rectangles sustain one request per cycle while the output is
// ready. A partial one holds the back end for each vertex and, per edge crossing,
// for the run of the radix-256 divider. Reset is synchronous, active low.
module rect_half_plane_clipper_core (
  input  logic                              clk,
  input  logic                              rst_n,
  rhpc_in_if.sink                           in_ch,
  rhpc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rhpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rhpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rhpc_pkg::*;

  // The wipe line: center point and direction vector, which software must write
  // only while idle (not enforced). The direction resets to straight up (0, 1.0).
  coord_t cx_r, cy_r;
  dir_t   dx_r, dy_r;
  cfg_t   cfg;

  logic   push_valid, push_ready, pop_valid, pop;
  entry_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      dx_r <= '0;
      dy_r <= DIR_W'(1) << DIR_FRAC_BITS;
    end else if (cfg_we) begin
      // Writes to indexes past the last register are dropped.
      unique case (cfg_index)
        REG_CENTER_X: cx_r <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: cy_r <= cfg_data[COORD_W-1:0];
        REG_DIR_X:    dx_r <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:    dy_r <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.cx = cx_r;
  assign cfg.cy = cy_r;
  assign cfg.dx = dx_r;
  assign cfg.dy = dy_r;

  // The front end computes all four corner cross products in parallel lanes
  // and classes the rectangle; it keeps taking requests while the back end
  // is still emitting the vertices of an earlier one.
  rhpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The short queue lets the front and back ends stall independently.
  rhpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  // The back end emits corners and edge crossings in corner order; each
  // crossing is the edge start point plus a rounded quotient from its divider.
  rhpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

### hdl/rhpc_front.sv
// Front end: accepts rectangles, forms the four corner cross products and
// classifies them. Depends on rhpc_pkg and rhpc_in_if.
module rhpc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  rhpc_pkg::cfg_t   cfg,
  rhpc_in_if.sink          in_ch,
  output logic             push_valid,
  input  logic             push_ready,
  output rhpc_pkg::entry_t push_data
);
  import rhpc_pkg::*;

  logic en;
  logic va_r, vb_r, vc_r;

  coord_t a_x1_r, a_y1_r, a_x2_r, a_y2_r;
  coord_t b_x1_r, b_y1_r, b_x2_r, b_y2_r;
  coord_t c_x1_r, c_y1_r, c_x2_r, c_y2_r;
  dirn_t  a_dxn_r, a_dyn_r, b_dxn_r, b_dyn_r, c_dxn_r, c_dyn_r;
  dirn_t  sdx, sdy, dxn_nxt, dyn_nxt;
  logic signed [DIFF_W-1:0] a_xl_r, a_xr_r, a_yb_r, a_yt_r;
  logic signed [PROD_W-1:0] b_pb_r, b_pt_r, b_ql_r, b_qr_r;
  cross_t [3:0] c_cr_r;
  logic [3:0] neg, pos;
  logic [NSLOT-1:0] mask;
  logic [1:0] cls;

  assign en          = !vc_r || push_ready;
  assign in_ch.ready = en;
  assign push_valid  = vc_r;

  always_comb begin
    sdx     = DIRN_W'(cfg.dx);
    sdy     = DIRN_W'(cfg.dy);
    dxn_nxt = in_ch.keep_right ? -sdx : sdx;
    dyn_nxt = in_ch.keep_right ? -sdy : sdy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_ch.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x1_r  <= in_ch.rect_left;
      a_y1_r  <= in_ch.rect_bottom;
      a_x2_r  <= in_ch.rect_right;
      a_y2_r  <= in_ch.rect_top;
      a_dxn_r <= dxn_nxt;
      a_dyn_r <= dyn_nxt;
      a_xl_r  <= DIFF_W'(in_ch.rect_left) - DIFF_W'(cfg.cx);
      a_xr_r  <= DIFF_W'(in_ch.rect_right) - DIFF_W'(cfg.cx);
      a_yb_r  <= DIFF_W'(in_ch.rect_bottom) - DIFF_W'(cfg.cy);
      a_yt_r  <= DIFF_W'(in_ch.rect_top) - DIFF_W'(cfg.cy);

      b_x1_r  <= a_x1_r;
      b_y1_r  <= a_y1_r;
      b_x2_r  <= a_x2_r;
      b_y2_r  <= a_y2_r;
      b_dxn_r <= a_dxn_r;
      b_dyn_r <= a_dyn_r;
      b_pb_r  <= a_dxn_r * a_yb_r;
      b_pt_r  <= a_dxn_r * a_yt_r;
      b_ql_r  <= a_dyn_r * a_xl_r;
      b_qr_r  <= a_dyn_r * a_xr_r;

      c_x1_r    <= b_x1_r;
      c_y1_r    <= b_y1_r;
      c_x2_r    <= b_x2_r;
      c_y2_r    <= b_y2_r;
      c_dxn_r   <= b_dxn_r;
      c_dyn_r   <= b_dyn_r;
      c_cr_r[0] <= CROSS_W'(b_pb_r) - CROSS_W'(b_ql_r);
      c_cr_r[1] <= CROSS_W'(b_pb_r) - CROSS_W'(b_qr_r);
      c_cr_r[2] <= CROSS_W'(b_pt_r) - CROSS_W'(b_qr_r);
      c_cr_r[3] <= CROSS_W'(b_pt_r) - CROSS_W'(b_ql_r);
    end
  end

  // Slot 2i is corner i, slot 2i+1 is the strict crossing on the edge after it.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg[i] = c_cr_r[i][CROSS_W-1];
      pos[i] = !neg[i] && (c_cr_r[i] != '0);
    end
    for (int i = 0; i < 4; i++) begin
      mask[2*i]   = !neg[i];
      mask[2*i+1] = (pos[i] && neg[(i+1)%4]) || (neg[i] && pos[(i+1)%4]);
    end
    if (neg == 4'b0000) begin
      cls  = CLS_FULL;
      mask = NSLOT'(1);
    end else if (pos == 4'b0000) begin
      cls  = CLS_EMPTY;
      mask = NSLOT'(1);
    end else begin
      cls = CLS_PARTIAL;
    end
  end

  always_comb begin
    push_data.cls  = cls;
    push_data.mask = mask;
    push_data.x1   = c_x1_r;
    push_data.y1   = c_y1_r;
    push_data.x2   = c_x2_r;
    push_data.y2   = c_y2_r;
    push_data.dxn  = c_dxn_r;
    push_data.dyn  = c_dyn_r;
    push_data.cr   = c_cr_r;
  end

endmodule

### hdl/rhpc_fifo.sv
// Two-entry queue of classified rectangles between front and back ends.
// Depends on rhpc_pkg for the entry type.
module rhpc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  rhpc_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop,
  output rhpc_pkg::entry_t pop_data
);
  import rhpc_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### hdl/rhpc_back.sv
// Back end: walks the emission slots of one rectangle, runs the crossing
// divider and drives the registered vertex output. Depends on rhpc_pkg,
// rhpc_out_if and assert_macros.svh.
`include "assert_macros.svh"
module rhpc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop,
  input  rhpc_pkg::entry_t pop_data,
  rhpc_out_if.source       out_ch
);
  import rhpc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  entry_t           ent_r;
  logic             busy_r;
  logic [NSLOT-1:0] mask_r, slot_oh;
  logic [SLOT_W-1:0] slot;
  logic [1:0]       ci;
  logic             last, vrdy, out_free, emit;
  coord_t           px, py, vx, vy;

  logic [1:0]           dv_ph_r;
  logic [DIV_CNT_W-1:0] dv_cnt_r;
  logic [DIRN_W-1:0]    dv_rem_r, dv_dm_r;
  logic [QUO_W-1:0]     dv_num_r, dv_q_r;
  logic                 dv_neg_r;
  coord_t               dv_res_r;

  cross_t            st_c;
  dirn_t             st_d;
  logic [CROSS_W-1:0] st_nm;
  logic [DIRN_W-1:0] st_dm, st_rem;
  logic [QUO_W-1:0]  st_num, st_q;
  logic [DIRN_W:0]   st_t;
  logic              st_rnd;
  coord_t            st_qm, st_res;

  logic             out_valid_r, out_last_r;
  logic [1:0]       out_cls_r;
  coord_t           out_x_r, out_y_r;

  always_comb begin
    slot = '0;
    for (int k = NSLOT - 1; k >= 0; k--) begin
      if (mask_r[k]) slot = SLOT_W'(k);
    end
    slot_oh  = NSLOT'(1) << slot;
    ci       = slot[2:1];
    last     = (mask_r & ~slot_oh) == '0;
    px       = (ci == 2'd0 || ci == 2'd3) ? ent_r.x1 : ent_r.x2;
    py       = ci[1] ? ent_r.y2 : ent_r.y1;
    vrdy     = !slot[0] || (dv_ph_r == PH_DONE);
    out_free = !out_valid_r || out_ch.ready;
    emit     = busy_r && vrdy && out_free;
    pop      = pop_valid && (!busy_r || (emit && last));
  end

  // Horizontal edges divide by dy, vertical edges by -dx.
  always_comb begin
    st_c  = ent_r.cr[ci];
    st_d  = ci[0] ? -ent_r.dxn : ent_r.dyn;
    st_nm = st_c[CROSS_W-1] ? CROSS_W'(-st_c) : CROSS_W'(st_c);
    st_dm = st_d[DIRN_W-1] ? DIRN_W'(-st_d) : DIRN_W'(st_d);
    st_rem = dv_rem_r;
    st_num = dv_num_r;
    st_q   = dv_q_r;
    st_t   = '0;
    for (int k = 0; k < DIV_RADIX; k++) begin
      st_t   = {st_rem, st_num[QUO_W-1]};
      st_num = st_num << 1;
      if (st_t >= {1'b0, dv_dm_r}) begin
        st_t = st_t - {1'b0, dv_dm_r};
        st_q = {st_q[QUO_W-2:0], 1'b1};
      end else begin
        st_q = {st_q[QUO_W-2:0], 1'b0};
      end
      st_rem = st_t[DIRN_W-1:0];
    end
    // Round half away from zero on the magnitude, then apply the sign.
    st_rnd = {dv_rem_r, 1'b0} >= {1'b0, dv_dm_r};
    st_qm  = dv_q_r[COORD_W-1:0] + COORD_W'(st_rnd);
    st_res = dv_neg_r ? -st_qm : st_qm;
  end

  always_comb begin
    vx = px;
    vy = py;
    if (slot[0]) begin
      if (!ci[0]) vx = px + dv_res_r;
      else        vy = py + dv_res_r;
    end
    if (ent_r.cls != CLS_PARTIAL) begin
      vx = '0;
      vy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      mask_r  <= '0;
      dv_ph_r <= PH_IDLE;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        mask_r <= pop_data.mask;
      end else if (emit) begin
        mask_r <= mask_r & ~slot_oh;
        if (last) busy_r <= 1'b0;
      end
      unique case (dv_ph_r)
        PH_IDLE: if (busy_r && slot[0]) dv_ph_r <= PH_RUN;
        PH_RUN:  if (dv_cnt_r == '0) dv_ph_r <= PH_FIN;
        PH_FIN:  dv_ph_r <= PH_DONE;
        PH_DONE: if (emit) dv_ph_r <= PH_IDLE;
        default: dv_ph_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ent_r <= pop_data;
    if (dv_ph_r == PH_IDLE) begin
      dv_cnt_r <= DIV_CNT_W'(DIV_STEPS - 1);
      dv_rem_r <= DIRN_W'(st_nm >> QUO_W);
      dv_num_r <= st_nm[QUO_W-1:0];
      dv_q_r   <= '0;
      dv_dm_r  <= st_dm;
      dv_neg_r <= st_c[CROSS_W-1] ^ st_d[DIRN_W-1];
    end else if (dv_ph_r == PH_RUN) begin
      dv_cnt_r <= dv_cnt_r - DIV_CNT_W'(1);
      dv_rem_r <= st_rem;
      dv_num_r <= st_num;
      dv_q_r   <= st_q;
    end else if (dv_ph_r == PH_FIN) begin
      dv_res_r <= st_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cls_r  <= ent_r.cls;
      out_x_r    <= vx;
      out_y_r    <= vy;
      out_last_r <= last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.region_class = out_cls_r;
  assign out_ch.vertex_x     = out_x_r;
  assign out_ch.vertex_y     = out_y_r;
  assign out_ch.last_vertex  = out_last_r;

  `RHPC_ASSERT_IMP(a_div_on_cross, dv_ph_r != PH_IDLE, busy_r && slot[0])
  `RHPC_ASSERT_IMP(a_busy_has_slot, busy_r, mask_r != '0)
  `RHPC_ASSERT_IMP(a_whole_single, emit && ent_r.cls != CLS_PARTIAL, last)
  `RHPC_ASSERT_IMP(a_fin_after_run, dv_ph_r == PH_FIN, $past(dv_ph_r) == PH_RUN)

endmodule

### bench/tb_rect_half_plane_clipper_core.sv
// Self-checking testbench of the rectangle half-plane clipper top level.
// Depends on rhpc_pkg, the rhpc_in_if / rhpc_out_if interfaces and the core RTL.
`timescale 1ns / 100ps

module tb_rect_half_plane_clipper_core;
  import rhpc_pkg::*;

  // Register indexes that the core has no register behind; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 200;

  typedef struct {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
    logic   keep_right;
  } rect_t;

  typedef struct {
    logic [1:0] cls;
    coord_t     x;
    coord_t     y;
    logic       last;
  } vertex_t;

  // Keeps its own copy of the wipe line registers, turns each accepted
  // rectangle into its expected vertex stream and checks the vertices that leave.
  class clip_scoreboard;
    coord_t    center_x = '0;
    coord_t    center_y = '0;
    dir_t      dir_x = '0;
    dir_t      dir_y = 16'sd16384;
    vertex_t   expected_vertices[$];
    int        errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_X: center_x = data[COORD_W-1:0];
        REG_CENTER_Y: center_y = data[COORD_W-1:0];
        REG_DIR_X:    dir_x = data[DIR_W-1:0];
        REG_DIR_Y:    dir_y = data[DIR_W-1:0];
        default: ;
      endcase
    endfunction

    // Quotient rounded to nearest, ties away from zero.
    function longint round_div(longint num, longint den);
      longint nm, dm, q, r;
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      if (dm == 0) return 0;
      q = nm / dm;
      r = nm % dm;
      if (r >= dm - r) q++;
      return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function void push(logic [1:0] cls, longint x, longint y);
      vertex_t v;
      v.cls = cls;
      v.x = x[COORD_W-1:0];
      v.y = y[COORD_W-1:0];
      v.last = 1'b0;
      expected_vertices.push_back(v);
    endfunction

    function void note_request(rect_t r);
      longint dx, dy, cx, cy;
      longint px[4], py[4], cr[4];
      bit neg[4], pos[4];
      bit all_ge, all_le;
      int n, j;
      dx = longint'(dir_x);
      dy = longint'(dir_y);
      cx = longint'(center_x);
      cy = longint'(center_y);
      if (r.keep_right) begin
        dx = -dx;
        dy = -dy;
      end
      px[0] = r.left;  py[0] = r.bottom;
      px[1] = r.right; py[1] = r.bottom;
      px[2] = r.right; py[2] = r.top;
      px[3] = r.left;  py[3] = r.top;
      all_ge = 1;
      all_le = 1;
      for (int i = 0; i < 4; i++) begin
        cr[i] = dx * (py[i] - cy) - dy * (px[i] - cx);
        neg[i] = cr[i] < 0;
        pos[i] = cr[i] > 0;
        if (neg[i]) all_ge = 0;
        if (pos[i]) all_le = 0;
      end
      if (all_ge) begin
        push(CLS_FULL, 0, 0);
      end else if (all_le) begin
        push(CLS_EMPTY, 0, 0);
      end else begin
        n = 0;
        for (int i = 0; i < 4 && n < 5; i++) begin
          j = (i + 1) % 4;
          if (!neg[i]) begin
            push(CLS_PARTIAL, px[i], py[i]);
            n++;
          end
          if (n < 5 && ((pos[i] && neg[j]) || (neg[i] && pos[j]))) begin
            // Bottom and top edges are horizontal, the other two vertical.
            if (i % 2 == 0) push(CLS_PARTIAL, px[i] + round_div(cr[i], dy), py[i]);
            else push(CLS_PARTIAL, px[i], py[i] + round_div(cr[i], -dx));
            n++;
          end
        end
      end
      expected_vertices[$].last = 1'b1;
    endfunction

    function void check_result(vertex_t got);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex cls=%0d x=%h y=%h last=%b",
                                   got.cls, got.x, got.y, got.last);
        return;
      end
      want = expected_vertices.pop_front();
      if (got.cls !== want.cls || got.x !== want.x || got.y !== want.y ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"vertex mismatch: expected cls=%0d x=%h y=%h last=%b,",
                    " got cls=%0d x=%h y=%h last=%b"},
                   want.cls, want.x, want.y, want.last, got.cls, got.x, got.y, got.last);
      end
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int cycles = 0;
  bit burst = 0;   // when set, both sides run without idle gaps

  rhpc_in_if  in_ch ();
  rhpc_out_if out_ch ();

  clip_scoreboard sb = new();

  rect_half_plane_clipper_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rect_half_plane_clipper_core verification failed");
      $finish;
    end
  end

  // Every vertex accepted at a rising edge is checked against the oldest
  // expectation. Sampling here sees the values from before the edge.
  always @(posedge clk) begin
    vertex_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cls = out_ch.region_class;
      got.x = out_ch.vertex_x;
      got.y = out_ch.vertex_y;
      got.last = out_ch.last_vertex;
      sb.check_result(got);
    end
  end

  // Receiver: for each vertex it draws an idle gap, then holds ready until a
  // vertex is taken. Ready is only lowered when the gap is nonzero, so it is
  // never lowered and raised within one time step.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Sends one rectangle request. Called and returns at a falling edge; valid
  // is left high so that a back-to-back request only changes the payload.
  task automatic send_rect(rect_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.rect_left <= r.left;
    in_ch.rect_bottom <= r.bottom;
    in_ch.rect_right <= r.right;
    in_ch.rect_top <= r.top;
    in_ch.keep_right <= r.keep_right;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Drops valid, then waits until every expected vertex has left and the pipeline
  // has drained. Only then may registers change.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write per cycle; the write enable stays high so that a run of
  // writes needs no gap, and end_writes drops it afterwards.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Writes the whole wipe line setting; the upper data bits of the direction
  // writes carry noise, which the core must drop.
  task automatic set_line(coord_t cx, coord_t cy, dir_t dx, dir_t dy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_DIR_X, {16'($urandom), dx});
    write_reg(REG_DIR_Y, {16'($urandom), dy});
  endtask

  function automatic rect_t make_rect(coord_t l, coord_t b, coord_t r, coord_t t, logic k);
    rect_t q;
    q.left = l; q.bottom = b; q.right = r; q.top = t; q.keep_right = k;
    return q;
  endfunction

  // Random rectangle: mostly small ones around the center so that the line
  // cuts them, sometimes full-range coordinates to toggle every bit.
  function automatic rect_t random_rect();
    rect_t q;
    int span;
    if ($urandom_range(0, 4) == 0) begin
      q = make_rect($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    end else begin
      span = 1 << $urandom_range(2, 22);
      q.left = sb.center_x + $signed($urandom_range(0, 2 * span)) - span;
      q.right = sb.center_x + $signed($urandom_range(0, 2 * span)) - span;
      q.bottom = sb.center_y + $signed($urandom_range(0, 2 * span)) - span;
      q.top = sb.center_y + $signed($urandom_range(0, 2 * span)) - span;
      q.keep_right = 1'($urandom_range(0, 1));
    end
    return q;
  endfunction

  function automatic dir_t random_dir();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sh8000;      // out of range pattern, still used as is
      3: return 16'sd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic coord_t random_center();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  initial begin
    int sent;
    in_ch.valid = 1'b0;
    in_ch.rect_left = '0;
    in_ch.rect_bottom = '0;
    in_ch.rect_right = '0;
    in_ch.rect_top = '0;
    in_ch.keep_right = 1'b0;
    // Synchronous reset, held from time zero and released only here.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset line: vertical line through the origin,
    // kept side x <= 0 (cross = -16384 * x).
    send_rect(make_rect(-32'sd100, -32'sd50, -32'sd10, 32'sd50, 1'b0));   // full
    send_rect(make_rect(32'sd10, -32'sd50, 32'sd100, 32'sd50, 1'b0));     // empty
    send_rect(make_rect(-32'sd100, -32'sd50, 32'sd100, 32'sd50, 1'b0));   // partial
    send_rect(make_rect(-32'sd100, -32'sd50, 32'sd100, 32'sd50, 1'b1));   // other side
    send_rect(make_rect(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));           // point on line
    send_rect(make_rect(32'sd0, -32'sd5, 32'sd0, 32'sd5, 1'b1));          // zero width
    send_rect(make_rect(32'sd100, 32'sd50, -32'sd100, -32'sd50, 1'b0));   // inverted
    send_rect(make_rect(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh7fff_ffff, 1'b0));
    send_rect(make_rect(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh8000_0000, 1'b1));
    drain();

    // Diagonal line, off-center: edge crossings on both edge kinds.
    set_line(32'sd1000, -32'sd2000, -16'sd11585, 16'sd11585);
    write_reg(REG_SPARE_FIRST, $urandom);
    write_reg(REG_SPARE_LAST, $urandom);
    end_writes();
    send_rect(make_rect(32'sd0, -32'sd3000, 32'sd2000, -32'sd1000, 1'b0));
    send_rect(make_rect(32'sd0, -32'sd3000, 32'sd2000, -32'sd1000, 1'b1));
    send_rect(make_rect(32'sd999, -32'sd2001, 32'sd1001, -32'sd1999, 1'b0));
    send_rect(make_rect(32'sd1000, -32'sd2000, 32'sd1003, -32'sd1997, 1'b1));
    send_rect(make_rect(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh7fff_ffff, 1'b0));
    drain();

    // Zero direction: everything is full.
    set_line(32'sd0, 32'sd0, 16'sd0, 16'sd0);
    end_writes();
    send_rect(make_rect(-32'sd7, -32'sd7, 32'sd7, 32'sd7, 1'b0));
    send_rect(make_rect(-32'sd7, -32'sd7, 32'sd7, 32'sd7, 1'b1));
    drain();

    // Most negative direction pattern with extreme centers: negation must be exact.
    set_line(32'sh7fff_ffff, 32'sh8000_0000, 16'sh8000, 16'sh8000);
    end_writes();
    send_rect(make_rect(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh7fff_ffff, 1'b0));
    send_rect(make_rect(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                        32'sh8000_0000, 1'b1));
    send_rect(make_rect(32'sh7fff_fff0, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh8000_0010, 1'b0));
    drain();

    // Random phases, each under a fresh line setting and idle profile.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_line(random_center(), random_center(), random_dir(), random_dir());
      end_writes();
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 30)) begin
        send_rect(random_rect());
        sent++;
      end
      drain();
      burst = 0;
    end

    // Drained above: nothing is expected and the pipeline has settled.
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rect_half_plane_clipper_core verification clean");
    end else begin
      $display("rect_half_plane_clipper_core verification failed");
    end
    $finish;
  end

endmodule
